// ===== rtl/qat_pkg.sv =====
// Shared types, codes and constants of the quoted argument tokenizer.
package qat_pkg;

   // Default size limits
   localparam int QAT_STORAGE_MAX = 4096;
   localparam int QAT_SLOT_MAX    = 64;

   // Result queue sizing: an end request yields at most three results
   localparam int QAT_MAX_RESULTS = 3;
   localparam int QAT_QUEUE_DEPTH = 4;

   // Configuration register widths and reset values
   localparam int QAT_CSR_WIDTH     = 13;
   localparam int QAT_STORAGE_WIDTH = 13;
   localparam int QAT_SLOTS_WIDTH   = 7;
   localparam logic [QAT_STORAGE_WIDTH-1:0] QAT_STORAGE_RESET = 13'd4096;
   localparam logic [QAT_SLOTS_WIDTH-1:0]   QAT_SLOTS_RESET   = 7'd64;

   // Special bytes
   localparam logic [7:0] CHAR_SQUOTE = 8'h27;
   localparam logic [7:0] CHAR_DQUOTE = 8'h22;
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_NUL    = 8'h00;

   // Configuration register indexes
   typedef enum logic {
      REG_STORAGE_BYTES = 1'b0,
      REG_WORD_SLOTS    = 1'b1
   } reg_index_type;

   // Result kinds
   typedef enum logic [1:0] {
      KIND_BYTE   = 2'd0,
      KIND_TERM   = 2'd1,
      KIND_STATUS = 2'd2
   } kind_type;

   // Final status codes
   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_OPEN      = 3'd1,
      ST_TOO_MANY  = 3'd2,
      ST_FULL      = 3'd3,
      ST_EMPTY     = 3'd4
   } status_type;

   // Parser phase
   typedef enum logic [1:0] {
      PH_BETWEEN = 2'd0,
      PH_WORD    = 2'd1,
      PH_ERROR   = 2'd2
   } phase_type;

   // Open quote
   typedef enum logic [1:0] {
      Q_NONE   = 2'd0,
      Q_SINGLE = 2'd1,
      Q_DOUBLE = 2'd2
   } quote_type;

   // What one byte does inside a word
   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_BYTE,
      ACT_TERM,
      ACT_ESC,
      ACT_OPEN_S,
      ACT_OPEN_D,
      ACT_CLOSE
   } act_type;

   // One result item
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  byte_out;
      logic [5:0]  word_index;
      logic [11:0] store_offset;
      status_type  status;
      logic [5:0]  word_count;
      logic        last;
   } rsp_type;

   // Build a stored byte or terminator result
   function automatic rsp_type make_store(kind_type kind, logic [7:0] value,
                                          logic [5:0] widx, logic [11:0] offset);
      rsp_type r;
      r.kind         = kind;
      r.byte_out     = value;
      r.word_index   = widx;
      r.store_offset = offset;
      r.status       = ST_OK;
      r.word_count   = 6'd0;
      r.last         = 1'b0;
      return r;
   endfunction

   // Build a final status result
   function automatic rsp_type make_status(status_type st, logic [5:0] count);
      rsp_type r;
      r.kind         = KIND_STATUS;
      r.byte_out     = CHAR_NUL;
      r.word_index   = 6'd0;
      r.store_offset = 12'd0;
      r.status       = st;
      r.word_count   = count;
      r.last         = 1'b1;
      return r;
   endfunction

endpackage

// ===== rtl/quoted_argument_tokenizer_top.sv =====
// Top level of the quoted argument tokenizer: parser state and result queue.

// Splits a command string, one byte per request, into shell-style arguments
// and emits every stored byte, a terminator per word and a final status on
// the first error or end request. Byte requests are taken every cycle while
// req_stall is low and yield at most one result; end requests up to three.
// Results go into a four-entry queue draining one result per cycle while
// rsp_stall is low; req_stall rises while it holds more than one, so with
// rsp_stall low bytes run at one per cycle. Configuration writes take effect
// at once and are meant to land between commands or while idle.
module quoted_argument_tokenizer_top
   import qat_pkg::*;
#(
   parameter int STORAGE_MAX = QAT_STORAGE_MAX,
   parameter int SLOT_MAX    = QAT_SLOT_MAX
) (
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [7:0]               req_char_in,
   input  logic                     req_is_end,
   // result channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [1:0]               rsp_kind,
   output logic [7:0]               rsp_byte_out,
   output logic [5:0]               rsp_word_index,
   output logic [11:0]              rsp_store_offset,
   output logic [2:0]               rsp_status,
   output logic [5:0]               rsp_word_count,
   output logic                     rsp_last,
   // configuration port
   input  logic                     csr_write_en,
   input  logic                     csr_index,
   input  logic [QAT_CSR_WIDTH-1:0] csr_wdata
);

   localparam int UW   = $clog2(STORAGE_MAX);
   localparam int WW   = $clog2(SLOT_MAX);
   localparam int CMPW = ((UW > QAT_STORAGE_WIDTH) ? UW : QAT_STORAGE_WIDTH) + 1;
   localparam int SCW  = ((WW > QAT_SLOTS_WIDTH) ? WW : QAT_SLOTS_WIDTH) + 1;
   localparam int PW   = $clog2(QAT_QUEUE_DEPTH);
   localparam int CNTW = $clog2(QAT_QUEUE_DEPTH + 1);
   localparam int NW   = $clog2(QAT_MAX_RESULTS + 1);
   localparam logic [CNTW-1:0] STALL_LEVEL = CNTW'(QAT_QUEUE_DEPTH - QAT_MAX_RESULTS);

   // Configuration registers
   logic [QAT_STORAGE_WIDTH-1:0] storage_ff, storage_in;
   logic [QAT_SLOTS_WIDTH-1:0]   slots_ff, slots_in;

   // Command state
   phase_type        phase_ff, phase_in;
   quote_type        quote_ff, quote_in;
   logic             esc_ff, esc_in;
   logic [UW-1:0]    used_ff, used_in;
   logic [WW-1:0]    words_ff, words_in;

   // Result queue
   rsp_type          queue_ff [QAT_QUEUE_DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]  count_ff, count_in;

   // Decode
   logic             req_accept;
   logic             rsp_pop;
   logic             char_space;
   logic [CMPW-1:0]  storage_cap;
   logic [SCW-1:0]   slot_cap;
   logic             room_one;
   logic             room_two;
   logic             slot_free;
   logic             slot_fail;
   logic             word_active;
   logic [WW-1:0]    words_eff;
   logic [7:0]       quote_char;
   act_type          act;
   logic [5:0]       widx;
   logic [5:0]       widx_eff;
   logic [11:0]      off_first;
   logic [11:0]      off_second;

   // Results of the current request
   rsp_type          entry [QAT_MAX_RESULTS];
   logic [NW-1:0]    push_n;

   assign req_stall  = count_ff > STALL_LEVEL;
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = count_ff != '0;
   assign rsp_pop    = rsp_valid && !rsp_stall;

   // Decode the byte against the current state
   always_comb begin
      char_space  = req_char_in inside {[8'd9:8'd13], 8'd32};
      storage_cap = (CMPW'(storage_ff) < CMPW'(STORAGE_MAX)) ?
                    CMPW'(storage_ff) : CMPW'(STORAGE_MAX);
      slot_cap    = (SCW'(slots_ff) < SCW'(SLOT_MAX)) ? SCW'(slots_ff) : SCW'(SLOT_MAX);
      room_one    = (CMPW'(used_ff) + CMPW'(1)) < storage_cap;
      room_two    = (CMPW'(used_ff) + CMPW'(2)) < storage_cap;
      slot_free   = (SCW'(words_ff) + SCW'(1)) < slot_cap;
      slot_fail   = (phase_ff == PH_BETWEEN) && !char_space && !slot_free;
      word_active = (phase_ff == PH_WORD) ||
                    ((phase_ff == PH_BETWEEN) && !char_space && slot_free);
      words_eff   = (phase_ff == PH_BETWEEN) ? words_ff + WW'(1) : words_ff;
      quote_char  = (quote_ff == Q_SINGLE) ? CHAR_SQUOTE : CHAR_DQUOTE;
      widx        = 6'(words_ff - WW'(1));
      widx_eff    = 6'(words_eff - WW'(1));
      off_first   = 12'(used_ff);
      off_second  = 12'(used_ff + UW'(1));

      if (esc_ff) begin
         act = ACT_BYTE;
      end else if (quote_ff != Q_NONE) begin
         if (req_char_in == quote_char) begin
            act = ACT_CLOSE;
         end else if (req_char_in == CHAR_BSLASH) begin
            act = ACT_ESC;
         end else begin
            act = ACT_BYTE;
         end
      end else if (req_char_in == CHAR_SQUOTE) begin
         act = ACT_OPEN_S;
      end else if (req_char_in == CHAR_DQUOTE) begin
         act = ACT_OPEN_D;
      end else if (req_char_in == CHAR_BSLASH) begin
         act = ACT_ESC;
      end else if (char_space) begin
         act = ACT_TERM;
      end else begin
         act = ACT_BYTE;
      end
   end

   // Next command state
   always_comb begin
      phase_in = phase_ff;
      quote_in = quote_ff;
      esc_in   = esc_ff;
      used_in  = used_ff;
      words_in = words_ff;
      if (req_accept) begin
         if (req_is_end) begin
            phase_in = PH_BETWEEN;
            quote_in = Q_NONE;
            esc_in   = 1'b0;
            used_in  = '0;
            words_in = '0;
         end else if (phase_ff != PH_ERROR) begin
            if (slot_fail) begin
               phase_in = PH_ERROR;
            end else if (word_active) begin
               phase_in = PH_WORD;
               words_in = words_eff;
               case (act)
                  ACT_BYTE: begin
                     esc_in = 1'b0;
                     if (room_one) begin
                        used_in = used_ff + UW'(1);
                     end else begin
                        phase_in = PH_ERROR;
                     end
                  end
                  ACT_TERM: begin
                     if (room_one) begin
                        used_in  = used_ff + UW'(1);
                        phase_in = PH_BETWEEN;
                     end else begin
                        phase_in = PH_ERROR;
                     end
                  end
                  ACT_ESC:    esc_in   = 1'b1;
                  ACT_OPEN_S: quote_in = Q_SINGLE;
                  ACT_OPEN_D: quote_in = Q_DOUBLE;
                  ACT_CLOSE:  quote_in = Q_NONE;
                  default:    phase_in = phase_ff;
               endcase
            end
         end
      end
   end

   // Results of the accepted request
   always_comb begin
      entry[0] = make_status(ST_OK, 6'(words_ff));
      entry[1] = entry[0];
      entry[2] = entry[0];
      push_n   = '0;
      if (req_accept) begin
         if (req_is_end) begin
            case (phase_ff)
               PH_BETWEEN: begin
                  entry[0] = make_status((words_ff == '0) ? ST_EMPTY : ST_OK,
                                         6'(words_ff));
                  push_n   = NW'(1);
               end
               PH_WORD: begin
                  if (esc_ff) begin
                     if (!room_one) begin
                        entry[0] = make_status(ST_FULL, 6'(words_ff));
                        push_n   = NW'(1);
                     end else if (quote_ff != Q_NONE) begin
                        entry[0] = make_store(KIND_BYTE, CHAR_BSLASH, widx, off_first);
                        entry[1] = make_status(ST_OPEN, 6'(words_ff));
                        push_n   = NW'(2);
                     end else if (!room_two) begin
                        entry[0] = make_store(KIND_BYTE, CHAR_BSLASH, widx, off_first);
                        entry[1] = make_status(ST_FULL, 6'(words_ff));
                        push_n   = NW'(2);
                     end else begin
                        entry[0] = make_store(KIND_BYTE, CHAR_BSLASH, widx, off_first);
                        entry[1] = make_store(KIND_TERM, CHAR_NUL, widx, off_second);
                        entry[2] = make_status(ST_OK, 6'(words_ff));
                        push_n   = NW'(3);
                     end
                  end else if (quote_ff != Q_NONE) begin
                     entry[0] = make_status(ST_OPEN, 6'(words_ff));
                     push_n   = NW'(1);
                  end else if (!room_one) begin
                     entry[0] = make_status(ST_FULL, 6'(words_ff));
                     push_n   = NW'(1);
                  end else begin
                     entry[0] = make_store(KIND_TERM, CHAR_NUL, widx, off_first);
                     entry[1] = make_status(ST_OK, 6'(words_ff));
                     push_n   = NW'(2);
                  end
               end
               default: push_n = '0;
            endcase
         end else if (phase_ff != PH_ERROR) begin
            if (slot_fail) begin
               entry[0] = make_status(ST_TOO_MANY, 6'(words_ff));
               push_n   = NW'(1);
            end else if (word_active && (act == ACT_BYTE || act == ACT_TERM)) begin
               push_n = NW'(1);
               if (!room_one) begin
                  entry[0] = make_status(ST_FULL, 6'(words_eff));
               end else if (act == ACT_BYTE) begin
                  entry[0] = make_store(KIND_BYTE, req_char_in, widx_eff, off_first);
               end else begin
                  entry[0] = make_store(KIND_TERM, CHAR_NUL, widx_eff, off_first);
               end
            end
         end
      end
   end

   // Queue pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff + PW'(push_n);
      rd_ptr_in = rsp_pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff + CNTW'(push_n) - CNTW'(rsp_pop);
   end

   // Configuration writes
   always_comb begin
      storage_in = storage_ff;
      slots_in   = slots_ff;
      if (csr_write_en) begin
         case (reg_index_type'(csr_index))
            REG_STORAGE_BYTES: storage_in = csr_wdata[QAT_STORAGE_WIDTH-1:0];
            REG_WORD_SLOTS:    slots_in   = csr_wdata[QAT_SLOTS_WIDTH-1:0];
            default:           storage_in = storage_ff;
         endcase
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         storage_ff <= QAT_STORAGE_RESET;
         slots_ff   <= QAT_SLOTS_RESET;
         phase_ff   <= PH_BETWEEN;
         quote_ff   <= Q_NONE;
         esc_ff     <= 1'b0;
         used_ff    <= '0;
         words_ff   <= '0;
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         count_ff   <= '0;
      end else begin
         storage_ff <= storage_in;
         slots_ff   <= slots_in;
         phase_ff   <= phase_in;
         quote_ff   <= quote_in;
         esc_ff     <= esc_in;
         used_ff    <= used_in;
         words_ff   <= words_in;
         wr_ptr_ff  <= wr_ptr_in;
         rd_ptr_ff  <= rd_ptr_in;
         count_ff   <= count_in;
      end
   end

   // Write the new results into the queue
   always_ff @(posedge clock) begin
      for (int k = 0; k < QAT_MAX_RESULTS; k++) begin
         if (NW'(k) < push_n) begin
            queue_ff[wr_ptr_ff + PW'(k)] <= entry[k];
         end
      end
   end

   // Drive the head of the queue
   assign rsp_kind         = queue_ff[rd_ptr_ff].kind;
   assign rsp_byte_out     = queue_ff[rd_ptr_ff].byte_out;
   assign rsp_word_index   = queue_ff[rd_ptr_ff].word_index;
   assign rsp_store_offset = queue_ff[rd_ptr_ff].store_offset;
   assign rsp_status       = queue_ff[rd_ptr_ff].status;
   assign rsp_word_count   = queue_ff[rd_ptr_ff].word_count;
   assign rsp_last         = queue_ff[rd_ptr_ff].last;

`ifndef NO_ASSERTIONS
   // The queue never holds more than its depth
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNTW'(QAT_QUEUE_DEPTH))
      else $error("result queue overfilled");

   // An accepted request always finds room for its results
   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      req_accept |-> (CNTW'(QAT_QUEUE_DEPTH) - count_ff) >= CNTW'(push_n))
      else $error("request accepted without queue room");

   // An end request leaves the command state cleared
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_is_end) |=>
         (phase_ff == PH_BETWEEN && used_ff == '0 && words_ff == '0 && !esc_ff))
      else $error("command state not cleared after end request");

   // Between words there is no open quote and no pending escape
   a_between_clean: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_BETWEEN |-> (quote_ff == Q_NONE && !esc_ff))
      else $error("quote or escape left open between words");

   // Bytes after an error yield nothing
   a_error_silent: assert property (@(posedge clock) disable iff (reset)
      (req_accept && !req_is_end && phase_ff == PH_ERROR) |-> push_n == '0)
      else $error("result produced in error phase");
`endif

endmodule
